// File: design/shg_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the spatial hash grid
// no dependencies
package shg_pkg;

   localparam int MAX_OBJECTS_DEF    = 1024;
   localparam int MAX_CELLS_DEF      = 2048;
   localparam int MAX_CELL_SPAN_DEF  = 4;
   localparam int MAX_NEIGHBOURS_DEF = 64;

   localparam int OP_W       = 2;
   localparam int COORD_W    = 32;
   localparam int SPACING_W  = 31;
   localparam int DIST_W     = 31;
   localparam int NCELLS_W   = 12;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int IDX_MAX_W  = 16;
   localparam int DVD_W      = 33;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;
   localparam logic [NCELLS_W-1:0]  NCELLS_RESET  = 12'd2048;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WIDE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NCELLS  = 2'd1;

   localparam logic [COORD_W-1:0] HASH_X = 32'd92837111;
   localparam logic [COORD_W-1:0] HASH_Y = 32'd689287499;
   localparam logic [COORD_W-1:0] HASH_Z = 32'd283923481;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COORD_W-1:0]   z;
      logic [IDX_MAX_W-1:0] idx;
      logic [DIST_W-1:0]    radius;
   } item_type;

endpackage

// File: design/shg_front.sv
`timescale 1ns / 1ps
// front end: accepts items, drops unused opcodes, two-entry queue to the back end
// depends on shg_pkg
module shg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  shg_pkg::item_type req_item,
   output logic              q_valid,
   output shg_pkg::item_type q_item,
   input  logic              q_pop
);

   shg_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop, keep;

   assign req_ready = (fill_ff != 2'd2);
   assign keep      = (req_item.op == shg_pkg::OP_LOAD) || (req_item.op == shg_pkg::OP_BUILD)
                   || (req_item.op == shg_pkg::OP_QUERY);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// File: design/shg_divu.sv
`timescale 1ns / 1ps
// iterative unsigned divider, one quotient bit per cycle
// no dependencies
module shg_divu #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] trial;

   assign shifted   = {rem_ff, quo_ff[DVD_W-1]};
   assign trial     = {1'b0, shifted} - {2'b00, dvs_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[DVS_W+1]) begin
            rem_in = trial[DVS_W-1:0];
         end else begin
            rem_in = shifted[DVS_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], ~trial[DVS_W+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// File: design/shg_back.sv
`timescale 1ns / 1ps
// back end: particle store, build sequencer, query scan and result register
// depends on shg_pkg and shg_divu
module shg_back #(
   parameter int MAX_OBJECTS    = shg_pkg::MAX_OBJECTS_DEF,
   parameter int MAX_CELLS      = shg_pkg::MAX_CELLS_DEF,
   parameter int MAX_CELL_SPAN  = shg_pkg::MAX_CELL_SPAN_DEF,
   parameter int MAX_NEIGHBOURS = shg_pkg::MAX_NEIGHBOURS_DEF,
   localparam int ID_W = $clog2(MAX_OBJECTS),
   localparam int CW   = $clog2(MAX_CELLS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [shg_pkg::SPACING_W-1:0]   eff_spacing,
   input  logic [CW-1:0]                   eff_cells,
   input  logic                            q_valid,
   input  shg_pkg::item_type               q_item,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ID_W-1:0]                 rsp_neighbour_id,
   output logic                            rsp_id_valid,
   output logic                            rsp_last,
   output logic [shg_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int SP_W  = $clog2(MAX_CELL_SPAN + 1);
   localparam int NB_W  = $clog2(MAX_NEIGHBOURS + 1);
   localparam int POS_W = 3 * shg_pkg::COORD_W;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CLR     = 5'd1;
   localparam logic [4:0] S_BPOS    = 5'd2;
   localparam logic [4:0] S_FLOOR   = 5'd3;
   localparam logic [4:0] S_FWAIT   = 5'd4;
   localparam logic [4:0] S_HMUL    = 5'd5;
   localparam logic [4:0] S_HMOD    = 5'd6;
   localparam logic [4:0] S_HWAIT   = 5'd7;
   localparam logic [4:0] S_BCNT_RD = 5'd8;
   localparam logic [4:0] S_BCNT_WR = 5'd9;
   localparam logic [4:0] S_PFX_RD  = 5'd10;
   localparam logic [4:0] S_PFX_WR  = 5'd11;
   localparam logic [4:0] S_PL_HRD  = 5'd12;
   localparam logic [4:0] S_PL_CRD  = 5'd13;
   localparam logic [4:0] S_PL_WR   = 5'd14;
   localparam logic [4:0] S_QCS0    = 5'd15;
   localparam logic [4:0] S_QCS1    = 5'd16;
   localparam logic [4:0] S_QCS2    = 5'd17;
   localparam logic [4:0] S_QENT    = 5'd18;
   localparam logic [4:0] S_QENTW   = 5'd19;
   localparam logic [4:0] S_NEXT    = 5'd20;
   localparam logic [4:0] S_FIN     = 5'd21;

   // memories
   logic [POS_W-1:0] pos_mem [MAX_OBJECTS];
   logic [CW-1:0]    hash_mem [MAX_OBJECTS];
   logic [CNT_W-1:0] cs_mem [MAX_CELLS + 1];
   logic [ID_W-1:0]  ent_mem [MAX_OBJECTS];

   logic [POS_W-1:0] pos_rd_ff;
   logic [CW-1:0]    hash_rd_ff;
   logic [CNT_W-1:0] cs_rd_ff;
   logic [ID_W-1:0]  ent_rd_ff;

   logic             pos_we, pos_re, hm_we, hm_re, cs_we, cs_re, en_we, en_re;
   logic [ID_W-1:0]  pos_wa, pos_ra, hm_wa, hm_ra, en_wa, en_ra;
   logic [POS_W-1:0] pos_wd;
   logic [CW-1:0]    hm_wd, cs_wa, cs_ra;
   logic [CNT_W-1:0] cs_wd;
   logic [ID_W-1:0]  en_wd;

   // control and datapath registers
   logic [4:0]       state_ff, state_in;
   logic             query_ff, query_in;
   logic             built_ff, built_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CW-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [1:0]       axis_ff, axis_in;
   logic             side_ff, side_in;
   logic             neg_ff, neg_in;
   logic [shg_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [shg_pkg::COORD_W-1:0] cc_ff [3];
   logic [shg_pkg::COORD_W-1:0] cc_in [3];
   logic [shg_pkg::COORD_W-1:0] lo32_ff [3];
   logic [shg_pkg::COORD_W-1:0] lo32_in [3];
   logic [SP_W-1:0]  span_ff [3];
   logic [SP_W-1:0]  span_in [3];
   logic [SP_W-1:0]  off_ff [3];
   logic [SP_W-1:0]  off_in [3];
   logic [33:0]      lo_tmp_ff, lo_tmp_in;
   logic [shg_pkg::COORD_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]    h_ff, h_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [NB_W-1:0]  found_ff, found_in;
   logic             trunc_ff, trunc_in;
   logic [shg_pkg::STATUS_W-1:0] fin_status_ff, fin_status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic             rsp_idv_ff, rsp_idv_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [shg_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic                        push, push_idv, push_last;
   logic [ID_W-1:0]             push_id;
   logic [shg_pkg::STATUS_W-1:0] push_status;
   logic                        out_free;
   logic [shg_pkg::COORD_W-1:0] p_sel, hin, hcst, prod_lo, amag;
   logic [33:0]                 p_ext, d_ext, fv, fv_neg, q34, adj, fres;
   logic [34:0]                 sdiff;
   logic [shg_pkg::DVD_W-1:0]   fmag, div_dvd, div_quo;
   logic [shg_pkg::SPACING_W-1:0] div_dvs, div_rem;
   logic                        div_start, div_done;
   logic [CNT_W-1:0]            cs_val, pl_v;
   logic                        scan_done;

   shg_divu #(
      .DVD_W(shg_pkg::DVD_W),
      .DVS_W(shg_pkg::SPACING_W)
   ) u_divu (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      case (axis_ff)
         2'd0:    p_sel = pos_rd_ff[POS_W-1 -: shg_pkg::COORD_W];
         2'd1:    p_sel = pos_rd_ff[2*shg_pkg::COORD_W-1 -: shg_pkg::COORD_W];
         default: p_sel = pos_rd_ff[shg_pkg::COORD_W-1:0];
      endcase
      case (axis_ff)
         2'd0:    hcst = shg_pkg::HASH_X;
         2'd1:    hcst = shg_pkg::HASH_Y;
         default: hcst = shg_pkg::HASH_Z;
      endcase
   end

   assign p_ext   = {{2{p_sel[31]}}, p_sel};
   assign d_ext   = {3'b000, dist_ff};
   assign fv      = !query_ff ? p_ext : (side_ff ? p_ext + d_ext : p_ext - d_ext);
   assign fv_neg  = -fv;
   assign fmag    = fv[33] ? fv_neg[32:0] : fv[32:0];
   assign hin     = query_ff ? lo32_ff[axis_ff] + 32'(off_ff[axis_ff]) : cc_ff[axis_ff];
   assign prod_lo = hin * hcst;
   assign amag    = acc_ff[31] ? (~acc_ff + 32'd1) : acc_ff;

   assign div_start = (state_ff == S_FLOOR) || (state_ff == S_HMOD);
   assign div_dvd   = (state_ff == S_HMOD) ? {1'b0, amag} : fmag;
   assign div_dvs   = (state_ff == S_HMOD) ? shg_pkg::SPACING_W'(eff_cells) : eff_spacing;

   // floor division from the unsigned quotient and remainder
   assign q34   = {1'b0, div_quo};
   assign adj   = q34 + 34'(div_rem != '0);
   assign fres  = neg_ff ? -adj : q34;
   assign sdiff = {fres[33], fres} - {lo_tmp_ff[33], lo_tmp_ff};

   assign cs_val    = built_ff ? cs_rd_ff : '0;
   assign pl_v      = (cs_val != '0) ? cs_val - CNT_W'(1) : cs_val;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_done = (off_ff[0] == span_ff[0]) && (off_ff[1] == span_ff[1])
                   && (off_ff[2] == span_ff[2]);

   always_comb begin
      state_in      = state_ff;
      query_in      = query_ff;
      built_in      = built_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      addr_in       = addr_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      axis_in       = axis_ff;
      side_in       = side_ff;
      neg_in        = neg_ff;
      dist_in       = dist_ff;
      cc_in         = cc_ff;
      lo32_in       = lo32_ff;
      span_in       = span_ff;
      off_in        = off_ff;
      lo_tmp_in     = lo_tmp_ff;
      acc_in        = acc_ff;
      h_in          = h_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      found_in      = found_ff;
      trunc_in      = trunc_ff;
      fin_status_in = fin_status_ff;
      q_pop         = 1'b0;
      push          = 1'b0;
      push_id       = '0;
      push_idv      = 1'b0;
      push_last     = 1'b0;
      push_status   = shg_pkg::STATUS_OK;
      pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_re = 1'b0; pos_ra = '0;
      hm_we  = 1'b0; hm_wa  = '0; hm_wd  = '0; hm_re  = 1'b0; hm_ra  = '0;
      cs_we  = 1'b0; cs_wa  = '0; cs_wd  = '0; cs_re  = 1'b0; cs_ra  = '0;
      en_we  = 1'b0; en_wa  = '0; en_wd  = '0; en_re  = 1'b0; en_ra  = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  shg_pkg::OP_LOAD: begin
                     if (count_ff != CNT_W'(MAX_OBJECTS)) begin
                        pos_we   = 1'b1;
                        pos_wa   = count_ff[ID_W-1:0];
                        pos_wd   = {q_item.x, q_item.y, q_item.z};
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  shg_pkg::OP_BUILD: begin
                     built_in = 1'b1;
                     query_in = 1'b0;
                     addr_in  = '0;
                     state_in = S_CLR;
                  end
                  shg_pkg::OP_QUERY: begin
                     query_in      = 1'b1;
                     dist_in       = q_item.radius;
                     pend_valid_in = 1'b0;
                     found_in      = '0;
                     trunc_in      = 1'b0;
                     fin_status_in = shg_pkg::STATUS_OK;
                     axis_in       = 2'd0;
                     side_in       = 1'b0;
                     if (32'(q_item.idx) >= 32'(count_ff)) begin
                        fin_status_in = shg_pkg::STATUS_BAD_IDX;
                        state_in      = S_FIN;
                     end else begin
                        pos_re   = 1'b1;
                        pos_ra   = q_item.idx[ID_W-1:0];
                        state_in = S_FLOOR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // clear every bucket start, the extra end entry included
         S_CLR: begin
            cs_we   = 1'b1;
            cs_wa   = addr_ff;
            cs_wd   = '0;
            addr_in = addr_ff + CW'(1);
            if (addr_ff == CW'(MAX_CELLS)) begin
               i_in     = '0;
               total_in = '0;
               addr_in  = '0;
               state_in = (count_ff == '0) ? S_PFX_RD : S_BPOS;
            end
         end
         S_BPOS: begin
            pos_re   = 1'b1;
            pos_ra   = i_ff[ID_W-1:0];
            axis_in  = 2'd0;
            state_in = S_FLOOR;
         end
         S_FLOOR: begin
            neg_in   = fv[33];
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_done) begin
               if (!query_ff) begin
                  cc_in[axis_ff] = fres[31:0];
                  if (axis_ff == 2'd2) begin
                     axis_in  = 2'd0;
                     acc_in   = '0;
                     state_in = S_HMUL;
                  end else begin
                     axis_in  = axis_ff + 2'd1;
                     state_in = S_FLOOR;
                  end
               end else if (!side_ff) begin
                  lo_tmp_in        = fres;
                  lo32_in[axis_ff] = fres[31:0];
                  side_in          = 1'b1;
                  state_in         = S_FLOOR;
               end else if (!sdiff[34] && (sdiff >= 35'(MAX_CELL_SPAN))) begin
                  fin_status_in = shg_pkg::STATUS_WIDE;
                  state_in      = S_FIN;
               end else begin
                  span_in[axis_ff] = sdiff[SP_W-1:0];
                  side_in          = 1'b0;
                  if (axis_ff == 2'd2) begin
                     off_in[0] = '0;
                     off_in[1] = '0;
                     off_in[2] = '0;
                     axis_in   = 2'd0;
                     acc_in    = '0;
                     state_in  = S_HMUL;
                  end else begin
                     axis_in  = axis_ff + 2'd1;
                     state_in = S_FLOOR;
                  end
               end
            end
         end
         S_HMUL: begin
            acc_in = acc_ff ^ prod_lo;
            if (axis_ff == 2'd2) begin
               state_in = S_HMOD;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_HMOD: begin
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (div_done) begin
               h_in     = div_rem[CW-1:0];
               state_in = query_ff ? S_QCS0 : S_BCNT_RD;
            end
         end
         S_BCNT_RD: begin
            hm_we    = 1'b1;
            hm_wa    = i_ff[ID_W-1:0];
            hm_wd    = h_ff;
            cs_re    = 1'b1;
            cs_ra    = h_ff;
            state_in = S_BCNT_WR;
         end
         S_BCNT_WR: begin
            cs_we = 1'b1;
            cs_wa = h_ff;
            cs_wd = cs_val + CNT_W'(1);
            i_in  = i_ff + CNT_W'(1);
            if ((i_ff + CNT_W'(1)) == count_ff) begin
               addr_in  = '0;
               state_in = S_PFX_RD;
            end else begin
               state_in = S_BPOS;
            end
         end
         S_PFX_RD: begin
            if (addr_ff == eff_cells) begin
               cs_we    = 1'b1;
               cs_wa    = addr_ff;
               cs_wd    = total_ff;
               i_in     = '0;
               state_in = (count_ff == '0) ? S_IDLE : S_PL_HRD;
            end else begin
               cs_re    = 1'b1;
               cs_ra    = addr_ff;
               state_in = S_PFX_WR;
            end
         end
         S_PFX_WR: begin
            total_in = total_ff + cs_val;
            cs_we    = 1'b1;
            cs_wa    = addr_ff;
            cs_wd    = total_ff + cs_val;
            addr_in  = addr_ff + CW'(1);
            state_in = S_PFX_RD;
         end
         S_PL_HRD: begin
            hm_re    = 1'b1;
            hm_ra    = i_ff[ID_W-1:0];
            state_in = S_PL_CRD;
         end
         S_PL_CRD: begin
            cs_re    = 1'b1;
            cs_ra    = hash_rd_ff;
            state_in = S_PL_WR;
         end
         S_PL_WR: begin
            cs_we = 1'b1;
            cs_wa = hash_rd_ff;
            cs_wd = pl_v;
            if (pl_v < CNT_W'(MAX_OBJECTS)) begin
               en_we = 1'b1;
               en_wa = pl_v[ID_W-1:0];
               en_wd = i_ff[ID_W-1:0];
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = ((i_ff + CNT_W'(1)) == count_ff) ? S_IDLE : S_PL_HRD;
         end
         S_QCS0: begin
            cs_re    = 1'b1;
            cs_ra    = h_ff;
            state_in = S_QCS1;
         end
         S_QCS1: begin
            ptr_in   = cs_val;
            cs_re    = 1'b1;
            cs_ra    = h_ff + CW'(1);
            state_in = S_QCS2;
         end
         S_QCS2: begin
            end_in   = cs_val;
            state_in = S_QENT;
         end
         S_QENT: begin
            if ((ptr_ff < end_ff) && (ptr_ff < CNT_W'(MAX_OBJECTS))) begin
               if (found_ff == NB_W'(MAX_NEIGHBOURS)) begin
                  trunc_in = 1'b1;
                  state_in = S_FIN;
               end else begin
                  en_re    = 1'b1;
                  en_ra    = ptr_ff[ID_W-1:0];
                  ptr_in   = ptr_ff + CNT_W'(1);
                  state_in = S_QENTW;
               end
            end else begin
               state_in = S_NEXT;
            end
         end
         // the held id goes out once the next one is known
         S_QENTW: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  push     = 1'b1;
                  push_id  = pend_id_ff;
                  push_idv = 1'b1;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = ent_rd_ff;
               found_in      = found_ff + NB_W'(1);
               state_in      = S_QENT;
            end
         end
         S_NEXT: begin
            if (scan_done) begin
               state_in = S_FIN;
            end else begin
               if (off_ff[2] != span_ff[2]) begin
                  off_in[2] = off_ff[2] + SP_W'(1);
               end else begin
                  off_in[2] = '0;
                  if (off_ff[1] != span_ff[1]) begin
                     off_in[1] = off_ff[1] + SP_W'(1);
                  end else begin
                     off_in[1] = '0;
                     off_in[0] = off_ff[0] + SP_W'(1);
                  end
               end
               axis_in  = 2'd0;
               acc_in   = '0;
               state_in = S_HMUL;
            end
         end
         S_FIN: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               if (pend_valid_ff) begin
                  push_id     = pend_id_ff;
                  push_idv    = 1'b1;
                  push_status = trunc_ff ? shg_pkg::STATUS_TRUNC : shg_pkg::STATUS_OK;
               end else begin
                  push_status = fin_status_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_id_in     = rsp_id_ff;
      rsp_idv_in    = rsp_idv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = push_id;
         rsp_idv_in    = push_idv;
         rsp_last_in   = push_last;
         rsp_status_in = push_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         built_ff      <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         built_ff      <= built_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      i_ff          <= i_in;
      addr_ff       <= addr_in;
      total_ff      <= total_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      axis_ff       <= axis_in;
      side_ff       <= side_in;
      neg_ff        <= neg_in;
      dist_ff       <= dist_in;
      cc_ff         <= cc_in;
      lo32_ff       <= lo32_in;
      span_ff       <= span_in;
      off_ff        <= off_in;
      lo_tmp_ff     <= lo_tmp_in;
      acc_ff        <= acc_in;
      h_ff          <= h_in;
      pend_id_ff    <= pend_id_in;
      found_ff      <= found_in;
      trunc_ff      <= trunc_in;
      fin_status_ff <= fin_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_idv_ff    <= rsp_idv_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[pos_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (hm_we) begin
         hash_mem[hm_wa] <= hm_wd;
      end
      if (hm_re) begin
         hash_rd_ff <= hash_mem[hm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cs_we) begin
         cs_mem[cs_wa] <= cs_wd;
      end
      if (cs_re) begin
         cs_rd_ff <= cs_mem[cs_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (en_we) begin
         ent_mem[en_wa] <= en_wd;
      end
      if (en_re) begin
         ent_rd_ff <= ent_mem[en_ra];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neighbour_id = rsp_id_ff;
   assign rsp_id_valid     = rsp_idv_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: design/spatial_hash_grid.sv
`timescale 1ns / 1ps
// spatial hash grid top level: configuration registers, front end and back end
// depends on shg_pkg, shg_front, shg_back
//
// usage
//   req channel: one item per handshake, opcode load, build or query; opcode 3 is
//     accepted and dropped. a two-entry queue sits in front of the sequencer.
//   rsp channel: query results only, at most one id per item, last marks the end of a
//     query, status on the last item. load and build give nothing.
//   csr channel: always ready; index 0 cell spacing, index 1 bucket count.
//     write only while the block is idle.
// back end work (one item at a time; divisions use the bit-serial divider)
//   load: stores the position unless the store is full
//   build: clears the bucket table, then for each loaded particle
//     three floor divisions plus a modulo, then prefix sums and placement
//   query: two floor divisions per axis for the cell box, then a modulo per cell
//     and one entry read per id found
// reset: clears control, loaded count and the built flag; the bucket table
//   reads as empty until the first build. stored positions are unknown.
// a stalled receiver holds the result register; the scan waits behind it
// while the front end keeps taking items until its queue fills
module spatial_hash_grid #(
   parameter int MAX_OBJECTS    = shg_pkg::MAX_OBJECTS_DEF,
   parameter int MAX_CELLS      = shg_pkg::MAX_CELLS_DEF,
   parameter int MAX_CELL_SPAN  = shg_pkg::MAX_CELL_SPAN_DEF,
   parameter int MAX_NEIGHBOURS = shg_pkg::MAX_NEIGHBOURS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [shg_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [shg_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [shg_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [shg_pkg::COORD_W-1:0] req_coord_z,
   input  logic [$clog2(MAX_OBJECTS)-1:0]    req_particle_index,
   input  logic [shg_pkg::DIST_W-1:0]        req_max_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [$clog2(MAX_OBJECTS)-1:0]    rsp_neighbour_id,
   output logic                              rsp_id_valid,
   output logic                              rsp_last,
   output logic [shg_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [shg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [shg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_CELLS + 1);

   // configuration registers
   logic [shg_pkg::SPACING_W-1:0] cell_spacing_ff, cell_spacing_in;
   logic [shg_pkg::NCELLS_W-1:0]  num_cells_ff, num_cells_in;
   logic [shg_pkg::SPACING_W-1:0] eff_spacing;
   logic [CW-1:0]                 eff_cells;

   shg_pkg::item_type req_item;
   shg_pkg::item_type q_item;
   logic              q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cell_spacing_in = cell_spacing_ff;
      num_cells_in    = num_cells_ff;
      if (csr_valid) begin
         case (csr_index)
            shg_pkg::CSR_SPACING: cell_spacing_in = csr_wdata[shg_pkg::SPACING_W-1:0];
            shg_pkg::CSR_NCELLS:  num_cells_in    = csr_wdata[shg_pkg::NCELLS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_spacing_ff <= shg_pkg::SPACING_RESET;
         num_cells_ff    <= shg_pkg::NCELLS_RESET;
      end else begin
         cell_spacing_ff <= cell_spacing_in;
         num_cells_ff    <= num_cells_in;
      end
   end

   // zero spacing acts as one, bucket count clamps to 2 through the table size
   always_comb begin
      eff_spacing = (cell_spacing_ff == '0) ? shg_pkg::SPACING_W'(1) : cell_spacing_ff;
      if (32'(num_cells_ff) < 32'd2) begin
         eff_cells = CW'(2);
      end else if (32'(num_cells_ff) > 32'(MAX_CELLS)) begin
         eff_cells = CW'(MAX_CELLS);
      end else begin
         eff_cells = CW'(num_cells_ff);
      end
   end

   always_comb begin
      req_item.op     = req_opcode;
      req_item.x      = req_coord_x;
      req_item.y      = req_coord_y;
      req_item.z      = req_coord_z;
      req_item.idx    = shg_pkg::IDX_MAX_W'(req_particle_index);
      req_item.radius = req_max_distance;
   end

   shg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   shg_back #(
      .MAX_OBJECTS    (MAX_OBJECTS),
      .MAX_CELLS      (MAX_CELLS),
      .MAX_CELL_SPAN  (MAX_CELL_SPAN),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .eff_spacing      (eff_spacing),
      .eff_cells        (eff_cells),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_neighbour_id (rsp_neighbour_id),
      .rsp_id_valid     (rsp_id_valid),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

endmodule
